// ===== rtl/itoa_pkg.sv =====
// package: request kinds, microcode word layout and the control store
package itoa_pkg;

  // request kinds
  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_DEC16 = 2'd1;
  localparam logic [1:0] REQ_HEX16 = 2'd2;
  localparam logic [1:0] REQ_DEC32 = 2'd3;

  // digit store and bit-loop sizes
  localparam int NumDigits  = 10;
  localparam int DigitBits  = 4 * NumDigits;
  localparam int HexDigits  = 4;
  localparam int Dec16Bits  = 16;
  localparam int Dec32Bits  = 32;

  // ascii codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_UPPER = 8'h41;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  // microcode operations
  typedef enum logic [2:0] {
    OP_WAIT,
    OP_BYTE,
    OP_DABBLE,
    OP_SKIP,
    OP_SIGN,
    OP_DIGIT
  } op_t;

  typedef logic [2:0] step_t;

  // one control word: operation, jump target when done, alternate dispatch target
  typedef struct packed {
    op_t   op;
    step_t tgt;
    step_t alt;
  } ctl_t;

  // control store step numbers
  localparam step_t STEP_WAIT   = 3'd0;
  localparam step_t STEP_BYTE   = 3'd1;
  localparam step_t STEP_DABBLE = 3'd2;
  localparam step_t STEP_SKIP   = 3'd3;
  localparam step_t STEP_SIGN   = 3'd4;
  localparam step_t STEP_DIGIT  = 3'd5;

  // read-only control store
  function automatic ctl_t ucode(input step_t pc);
    ctl_t w;
    case (pc)
      STEP_WAIT:   w = '{op: OP_WAIT,   tgt: STEP_BYTE, alt: STEP_DABBLE};
      STEP_BYTE:   w = '{op: OP_BYTE,   tgt: STEP_WAIT, alt: STEP_WAIT};
      STEP_DABBLE: w = '{op: OP_DABBLE, tgt: STEP_SKIP, alt: STEP_WAIT};
      STEP_SKIP:   w = '{op: OP_SKIP,   tgt: STEP_SIGN, alt: STEP_WAIT};
      STEP_SIGN:   w = '{op: OP_SIGN,   tgt: STEP_DIGIT, alt: STEP_WAIT};
      STEP_DIGIT:  w = '{op: OP_DIGIT,  tgt: STEP_WAIT, alt: STEP_WAIT};
      default:     w = '{op: OP_WAIT,   tgt: STEP_BYTE, alt: STEP_DABBLE};
    endcase
    return w;
  endfunction

  // one digit to its ascii character, upper-case for ten and above
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d > 4'd9) begin
      c = CHAR_UPPER + {4'd0, d} - 8'd10;
    end else begin
      c = CHAR_ZERO + {4'd0, d};
    end
    return c;
  endfunction

endpackage

// ===== rtl/integer_to_ascii_formatter_core.sv =====
// top level: microcoded integer to ascii formatter
//
// Takes one request (raw byte, signed 16-bit decimal, 16-bit upper-case hex or
// signed 32-bit decimal) and sends its characters one per output transfer, with
// last set on the final one. One request is in work at a time; in_stall is low
// only while the sequencer sits at its wait step. Hex and decimal requests go
// through leading-zero skips and a sign step, which is passed whether or not a
// minus goes out. Decimal requests use the shift-and-add-3 binary to bcd loop,
// which takes one input bit per cycle. The output register lets the sequencer
// move on while a character waits to be taken.
module integer_to_ascii_formatter_core
  import itoa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic signed [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  ch,
  output logic        last
);

  // sequencer and datapath registers
  step_t                pc, pc_next;
  logic [31:0]          mag, mag_next;
  logic [DigitBits-1:0] bcd, bcd_next;
  logic [5:0]           cnt, cnt_next;
  logic [3:0]           ndig, ndig_next;
  logic                 neg, neg_next;
  logic                 out_valid_next;
  logic [7:0]           ch_next;
  logic                 last_next;

  ctl_t                 ctl;
  logic                 out_free;
  logic                 in_xfer;
  logic [15:0]          w16;
  logic [15:0]          mag16;
  logic [DigitBits-1:0] adj;

  assign ctl      = ucode(pc);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (ctl.op != OP_WAIT);
  assign in_xfer  = in_valid && !in_stall;
  assign w16      = value[15:0];
  assign mag16    = w16[15] ? (16'd0 - w16) : w16;

  // add 3 to every bcd digit of five or more
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] > 4'd4) ? (bcd[4*i +: 4] + 4'd3) : bcd[4*i +: 4];
    end
  end

  // microcode execution
  always_comb begin
    pc_next        = pc;
    mag_next       = mag;
    bcd_next       = bcd;
    cnt_next       = cnt;
    ndig_next      = ndig;
    neg_next       = neg;
    out_valid_next = out_valid && out_stall;
    ch_next        = ch;
    last_next      = last;
    case (ctl.op)
      OP_WAIT: begin
        if (in_xfer) begin
          case (req_type)
            REQ_BYTE: begin
              bcd_next = {value[7:0], {(DigitBits - 8){1'b0}}};
              neg_next = 1'b0;
              pc_next  = ctl.tgt;
            end
            REQ_DEC16: begin
              neg_next  = w16[15];
              mag_next  = {mag16, 16'd0};
              bcd_next  = '0;
              cnt_next  = 6'(Dec16Bits);
              ndig_next = 4'(NumDigits);
              pc_next   = ctl.alt;
            end
            REQ_HEX16: begin
              neg_next  = 1'b0;
              bcd_next  = {w16, {(DigitBits - 16){1'b0}}};
              cnt_next  = '0;
              ndig_next = 4'(HexDigits);
              pc_next   = ctl.alt;
            end
            default: begin
              neg_next  = value[31];
              mag_next  = value[31] ? (32'd0 - value) : value;
              bcd_next  = '0;
              cnt_next  = 6'(Dec32Bits);
              ndig_next = 4'(NumDigits);
              pc_next   = ctl.alt;
            end
          endcase
        end
      end
      OP_BYTE: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          ch_next        = bcd[DigitBits-1 -: 8];
          last_next      = 1'b1;
          pc_next        = ctl.tgt;
        end
      end
      OP_DABBLE: begin
        // one bit of the binary to bcd conversion per step
        if (cnt == '0) begin
          pc_next = ctl.tgt;
        end else begin
          bcd_next = {adj[DigitBits-2:0], mag[31]};
          mag_next = {mag[30:0], 1'b0};
          cnt_next = cnt - 6'd1;
        end
      end
      OP_SKIP: begin
        // drop leading zero digits, keep at least one
        if (bcd[DigitBits-1 -: 4] == 4'd0 && ndig > 4'd1) begin
          bcd_next  = {bcd[DigitBits-5:0], 4'd0};
          ndig_next = ndig - 4'd1;
        end else begin
          pc_next = ctl.tgt;
        end
      end
      OP_SIGN: begin
        if (!neg) begin
          pc_next = ctl.tgt;
        end else if (out_free) begin
          out_valid_next = 1'b1;
          ch_next        = CHAR_MINUS;
          last_next      = 1'b0;
          pc_next        = ctl.tgt;
        end
      end
      OP_DIGIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          ch_next        = digit_char(bcd[DigitBits-1 -: 4]);
          last_next      = (ndig == 4'd1);
          bcd_next       = {bcd[DigitBits-5:0], 4'd0};
          ndig_next      = ndig - 4'd1;
          if (ndig == 4'd1) begin
            pc_next = ctl.tgt;
          end
        end
      end
      default: begin
        pc_next = STEP_WAIT;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= STEP_WAIT;
      cnt       <= '0;
      ndig      <= 4'd1;
      out_valid <= 1'b0;
    end else begin
      pc        <= pc_next;
      cnt       <= cnt_next;
      ndig      <= ndig_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mag  <= mag_next;
    bcd  <= bcd_next;
    neg  <= neg_next;
    ch   <= ch_next;
    last <= last_next;
  end

`ifndef SYNTH
  // an accepted request leaves the wait step
  a_leave_wait: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("sequencer stayed at wait after a request transfer");

  // the bit counter runs only inside the conversion loop
  a_cnt_in_loop: assert property (@(posedge clk) disable iff (rst)
    cnt != 6'd0 |-> ctl.op == OP_DABBLE)
    else $error("bit counter nonzero outside the conversion loop");

  // digit emission always has a digit left
  a_digit_left: assert property (@(posedge clk) disable iff (rst)
    ctl.op == OP_DIGIT |-> ndig != 4'd0 && ndig <= 4'd10)
    else $error("digit count out of range while emitting");
`endif

endmodule

// ===== tb/tb_integer_to_ascii_formatter_core.sv =====
// testbench: integer to ascii formatter, randomized requests checked against a local predictor
module tb_integer_to_ascii_formatter_core;
  import itoa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 360;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_PRINTED = 50;

  localparam logic [7:0] ASCII_0 = "0";
  localparam logic [7:0] ASCII_A = "A";
  localparam logic [7:0] ASCII_DASH = "-";

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] operand;
  } request_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_xfer_t;

  // directed requests: field extremes, most negative values, zero groups, ignored high bits
  localparam request_t DIRECTED [26] = '{
    '{REQ_BYTE,  32'h0000_0000}, '{REQ_BYTE,  32'hFFFF_FFFF}, '{REQ_BYTE,  32'hA5A5_5A41},
    '{REQ_DEC16, 32'h0000_0000}, '{REQ_DEC16, 32'hFFFF_0001}, '{REQ_DEC16, 32'h0000_0009},
    '{REQ_DEC16, 32'h1234_FFFF}, '{REQ_DEC16, 32'h0000_7FFF}, '{REQ_DEC16, 32'hFFFF_8000},
    '{REQ_DEC16, 32'd10000},     '{REQ_DEC16, 32'hABCD_000A},
    '{REQ_HEX16, 32'h0000_0000}, '{REQ_HEX16, 32'h0000_FFFF}, '{REQ_HEX16, 32'h0000_000A},
    '{REQ_HEX16, 32'h0000_1000}, '{REQ_HEX16, 32'hDEAD_BEEF}, '{REQ_HEX16, 32'h5555_ABCD},
    '{REQ_DEC32, 32'h0000_0000}, '{REQ_DEC32, 32'hFFFF_FFFF}, '{REQ_DEC32, 32'h7FFF_FFFF},
    '{REQ_DEC32, 32'h8000_0000}, '{REQ_DEC32, 32'd100000001}, '{REQ_DEC32, 32'd100000000},
    '{REQ_DEC32, 32'd1000000000}, '{REQ_DEC32, 32'hC465_35F9}, '{REQ_DEC32, 32'd10}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         req_type = REQ_BYTE;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         ch;
  logic               last;

  request_t   pending_requests[$];
  char_xfer_t expected_text[$];
  char_xfer_t want;

  int n_total;
  int n_accepted;
  int n_chars;
  int n_errors;
  int kind_count[4];
  int idle_cycles;
  int gap_left;
  int stall_left;
  bit in_calm;
  bit out_calm;

  integer_to_ascii_formatter_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ch        (ch),
    .last      (last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // expected characters of one request, appended to the expected text
  function automatic void predict_chars(input logic [1:0] kind, input logic [31:0] operand);
    logic [31:0] mag;
    logic [31:0] base;
    logic [31:0] d;
    logic [7:0]  digits[$];
    logic [7:0]  text[$];
    bit          neg;
    neg = 1'b0;
    base = 32'd10;
    mag = '0;
    case (kind)
      REQ_BYTE: text.push_back(operand[7:0]);
      REQ_DEC16: begin
        neg = operand[15];
        mag = neg ? 32'h1_0000 - {16'h0, operand[15:0]} : {16'h0, operand[15:0]};
      end
      REQ_HEX16: begin
        base = 32'd16;
        mag = {16'h0, operand[15:0]};
      end
      default: begin
        neg = operand[31];
        mag = neg ? 32'h0 - operand : operand;
      end
    endcase
    if (kind != REQ_BYTE) begin
      do begin
        d = mag % base;
        digits.push_front(d > 9 ? ASCII_A + 8'(d - 10) : ASCII_0 + 8'(d));
        mag = mag / base;
      end while (mag != 0);
      if (neg) text.push_back(ASCII_DASH);
      foreach (digits[k]) text.push_back(digits[k]);
    end
    foreach (text[k]) expected_text.push_back('{ch: text[k], last: (k == text.size() - 1)});
  endfunction

  task automatic report_mismatch(input string what);
    if (n_errors < MAX_PRINTED) $display("mismatch at %0t ns: %s", $time, what);
    n_errors++;
  endtask

  // request driver: takes a transfer, predicts its text, then idles or presents the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      in_calm <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        predict_chars(req_type, value);
        kind_count[req_type]++;
        n_accepted++;
      end
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_requests.size() != 0) begin
        req_type <= pending_requests[0].kind;
        value <= pending_requests[0].operand;
        pending_requests.delete(0);
        in_valid <= 1'b1;
        if ($urandom_range(0, 39) == 0) in_calm <= !in_calm;
        gap_left <= in_calm ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall: random bursts, with calm stretches where no new burst starts
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      out_calm <= 1'b0;
    end else begin
      if ($urandom_range(0, 59) == 0) out_calm <= !out_calm;
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!out_calm && $urandom_range(0, 99) < 25) begin
        out_stall <= 1'b1;
        stall_left <= pick_gap();
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // character monitor: compare each transfer with the oldest expected character
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_chars++;
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last %0b", ch, last));
      end else begin
        want = expected_text.pop_front();
        if (ch !== want.ch)
          report_mismatch($sformatf("ch 0x%02h, expected 0x%02h", ch, want.ch));
        if (last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b (ch 0x%02h)", last, want.last,
                                    want.ch));
      end
    end
  end

  // cycles in a row with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("timeout: no transfer for %0d cycles, %0d chars still expected",
             IDLE_LIMIT, expected_text.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int         shape;
    int         width;
    logic [1:0]  kind;
    logic [31:0] operand;
    logic [31:0] p;

    foreach (DIRECTED[k]) pending_requests.push_back(DIRECTED[k]);

    // random requests: full-range values mixed with small magnitudes,
    // powers of ten, zero groups and sign extremes
    for (int i = 0; i < NUM_RANDOM; i++) begin
      kind = 2'($urandom_range(0, 3));
      shape = $urandom_range(0, 9);
      case (shape)
        0, 1, 2, 3: operand = $urandom;
        4, 5, 6: begin
          width = $urandom_range(1, 31);
          operand = $urandom & ((32'h1 << width) - 1);
        end
        7: begin
          p = 32'd1;
          repeat ($urandom_range(0, kind == REQ_DEC32 ? 9 : 4)) p = p * 10;
          operand = p + $urandom_range(0, 2) - 1;
        end
        8: begin
          if (kind == REQ_DEC32) operand = $urandom_range(1, 21) * 100000000 + $urandom_range(0, 99);
          else operand = $urandom_range(1, 3) * 10000 + $urandom_range(0, 9);
        end
        default: begin
          case ($urandom_range(0, 3))
            0: operand = 32'h8000_0000;
            1: operand = 32'h7FFF_FFFF;
            2: operand = {16'($urandom), 16'h8000};
            default: operand = {16'($urandom), 16'h7FFF};
          endcase
        end
      endcase
      if (shape >= 4 && shape <= 8 && $urandom_range(0, 1) == 1) operand = 32'h0 - operand;
      if (kind != REQ_DEC32 && $urandom_range(0, 1) == 1) operand[31:16] = 16'($urandom);
      pending_requests.push_back('{kind: kind, operand: operand});
    end
    n_total = pending_requests.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < n_total) @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d raw byte, %0d dec16, %0d hex16, %0d dec32",
             n_accepted, kind_count[REQ_BYTE], kind_count[REQ_DEC16], kind_count[REQ_HEX16],
             kind_count[REQ_DEC32]);
    $display("%0d characters compared, %0d mismatches", n_chars, n_errors);
    if (n_errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
